### sv/lgs_pkg.sv
// shared types and constants of the life generation step block
package lgs_pkg;

   localparam int ROW_W        = 64;
   localparam int GROUP_W      = 8;
   localparam int GROUPS       = ROW_W / GROUP_W;
   localparam int GROUP_POP_W  = $clog2(GROUP_W + 1);
   localparam int POP_W        = 7;
   localparam int TOTAL_W      = 19;
   localparam int IDX_W        = 12;
   localparam int GRID_WIDTH_W  = 7;
   localparam int GRID_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = GRID_WIDTH_W'(64);
   localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = GRID_HEIGHT_W'(64);

   localparam logic [CSR_INDEX_W-1:0] REG_GRID_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_HEIGHT = CSR_INDEX_W'(1);

   // B3/S23 rule counts
   localparam logic [3:0] BORN_COUNT = 4'd3;
   localparam logic [3:0] KEEP_COUNT = 4'd2;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // one column's bits as seen by its neighbors
   typedef struct packed {
      logic above;
      logic middle;
      logic row;
   } lgs_col_type;

   typedef struct packed {
      logic             emit_a;
      logic             emit_b;
      logic [IDX_W-1:0] idx_a;
      logic [IDX_W-1:0] idx_b;
   } lgs_ctrl_type;

   typedef struct packed {
      logic [ROW_W-1:0]   next_row;
      logic [IDX_W-1:0]   row_index;
      logic [POP_W-1:0]   row_population;
      logic [TOTAL_W-1:0] total_population;
      logic               frame_done;
   } lgs_result_type;

endpackage

### sv/lgs_cell.sv
// one grid column: holds the two previous rows and computes the next-generation bits
module lgs_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                is_first,
   input  logic                is_last,
   input  logic                col_enable,
   input  logic                row_bit,
   input  lgs_pkg::lgs_col_type left_col,
   input  lgs_pkg::lgs_col_type right_col,
   output lgs_pkg::lgs_col_type own_col,
   output logic                next_a,
   output logic                next_b
);
   import lgs_pkg::*;

   logic       above_ff, above_in;
   logic       middle_ff, middle_in;
   logic       next_a_ff, next_a_in;
   logic       next_b_ff, next_b_in;
   logic       row_m;
   logic [3:0] cnt_a;
   logic [3:0] cnt_b;

   assign row_m = row_bit & col_enable;

   always_comb begin
      own_col.above  = above_ff;
      own_col.middle = middle_ff;
      own_col.row    = row_m;
   end

   // row r-1 with neighbors above and row; last row with no row below
   always_comb begin
      cnt_a = 4'(left_col.above) + 4'(above_ff) + 4'(right_col.above)
            + 4'(left_col.middle) + 4'(right_col.middle)
            + 4'(left_col.row) + 4'(row_m) + 4'(right_col.row);
      cnt_b = 4'(left_col.middle) + 4'(middle_ff) + 4'(right_col.middle)
            + 4'(left_col.row) + 4'(right_col.row);
      next_a_in = col_enable & ((cnt_a == BORN_COUNT) | (middle_ff & (cnt_a == KEEP_COUNT)));
      next_b_in = col_enable & ((cnt_b == BORN_COUNT) | (row_m & (cnt_b == KEEP_COUNT)));
   end

   always_comb begin
      above_in  = above_ff;
      middle_in = middle_ff;
      if (load) begin
         if (is_last) begin
            above_in  = 1'b0;
            middle_in = 1'b0;
         end else begin
            above_in  = middle_ff & ~is_first;
            middle_in = row_m;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         above_ff  <= above_in;
         middle_ff <= middle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         next_a_ff <= next_a_in;
         next_b_ff <= next_b_in;
      end
   end

   assign next_a = next_a_ff;
   assign next_b = next_b_ff;

endmodule

### sv/lgs_popcount.sv
// two-stage registered population count of one row
module lgs_popcount (
   input  logic                        clock,
   input  logic [lgs_pkg::ROW_W-1:0]   bits_in,
   output logic [lgs_pkg::POP_W-1:0]   pop_out
);
   import lgs_pkg::*;

   logic [GROUPS-1:0][GROUP_POP_W-1:0] part_ff, part_in;
   logic [POP_W-1:0]                   pop_ff, pop_in;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = '0;
         for (int b = 0; b < GROUP_W; b++) begin
            part_in[g] = part_in[g] + GROUP_POP_W'(bits_in[g*GROUP_W + b]);
         end
      end
   end

   always_comb begin
      pop_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         pop_in = pop_in + POP_W'(part_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      pop_ff  <= pop_in;
   end

   assign pop_out = pop_ff;

endmodule

### sv/lgs_out_queue.sv
// result queue: up to two pushes and one pop per cycle
module lgs_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_a,
   input  lgs_pkg::lgs_result_type data_a,
   input  logic                    push_b,
   input  lgs_pkg::lgs_result_type data_b,
   input  logic                    pop,
   output logic                    out_valid,
   output lgs_pkg::lgs_result_type out_data
);
   import lgs_pkg::*;

   lgs_result_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wptr_ff, wptr_in;
   logic [QPTR_W-1:0]       rptr_ff, rptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    do_pop;
   logic [QPTR_W-1:0]       wptr_b;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rptr_ff];
   assign do_pop    = pop & out_valid;
   assign wptr_b    = wptr_ff + QPTR_W'(push_a);

   always_comb begin
      wptr_in  = wptr_ff + QPTR_W'(push_a) + QPTR_W'(push_b);
      rptr_in  = rptr_ff + QPTR_W'(do_pop);
      count_in = count_ff + QCNT_W'(push_a) + QCNT_W'(push_b) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         mem_ff[wptr_ff] <= data_a;
      end
      if (push_b) begin
         mem_ff[wptr_b] <= data_b;
      end
   end

endmodule

### sv/life_generation_step.sv
// top level of the life generation step block (B3/S23, dead border)
//
// usage
//   req channel: one grid row per request (bit i = column i, 1 alive), rows in
//   order from row 0. rsp channel: next-generation rows with their index, row
//   population, running population and a frame_done flag on the last row.
//   csr port: register 0 grid_width, register 1 grid_height, written while idle.
// pipeline and throughput
//   one request per cycle while req_ready is high. a request yields no result
//   on the first row of a frame, one result on a middle row, two on the last
//   row. a result passes the cell row, two popcount stages and the queue.
//   the rate is set by the row of column cells, which updates all columns of a
//   row together, and by the 8-entry result queue, whose free slots are
//   counted at request time; req_ready needs two free slots for any row, since
//   a last row yields two results, so a stalled rsp side drops it at 7 taken.
// reset
//   synchronous; clears the held rows, row counter, running population, the
//   queue and the credit count; grid_width and grid_height return to 64.
module life_generation_step #(
   parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lgs_pkg::ROW_W-1:0]         req_row_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lgs_pkg::ROW_W-1:0]         rsp_next_row,
   output logic [lgs_pkg::IDX_W-1:0]         rsp_row_index,
   output logic [lgs_pkg::POP_W-1:0]         rsp_row_population,
   output logic [lgs_pkg::TOTAL_W-1:0]       rsp_total_population,
   output logic                              rsp_frame_done,
   input  logic                              csr_write_enable,
   input  logic [lgs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lgs_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import lgs_pkg::*;

   // row counter covers 0..MAX_HEIGHT-1
   localparam int CntW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   // compare width for the height limit and the counter
   localparam int CmpW = ((CntW > GRID_HEIGHT_W) ? CntW : GRID_HEIGHT_W) + 2;

   // configuration registers
   logic [GRID_WIDTH_W-1:0]  grid_width_ff, grid_width_in;
   logic [GRID_HEIGHT_W-1:0] grid_height_ff, grid_height_in;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_GRID_WIDTH:  grid_width_in  = GRID_WIDTH_W'(csr_write_data);
            REG_GRID_HEIGHT: grid_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // clamped width and height
   logic [GRID_WIDTH_W-1:0] eff_width;
   logic [CmpW-1:0]         eff_height;

   always_comb begin
      if (grid_width_ff == '0) begin
         eff_width = GRID_WIDTH_W'(1);
      end else if (grid_width_ff > GRID_WIDTH_W'(MAX_WIDTH)) begin
         eff_width = GRID_WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_width = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         eff_height = CmpW'(1);
      end else if (CmpW'(grid_height_ff) > CmpW'(MAX_HEIGHT)) begin
         eff_height = CmpW'(MAX_HEIGHT);
      end else begin
         eff_height = CmpW'(grid_height_ff);
      end
   end

   // request side control
   logic            accept;
   logic [CntW-1:0] rows_seen_ff, rows_seen_in;
   logic            is_first;
   logic            is_last;
   logic [1:0]      n_results;

   assign accept   = req_valid & req_ready;
   assign is_first = (rows_seen_ff == '0);
   assign is_last  = ((CmpW'(rows_seen_ff) + CmpW'(1)) >= eff_height);
   assign n_results = 2'(!is_first) + 2'(is_last);

   always_comb begin
      rows_seen_in = rows_seen_ff;
      if (accept) begin
         rows_seen_in = is_last ? '0 : rows_seen_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_seen_ff <= '0;
      end else begin
         rows_seen_ff <= rows_seen_in;
      end
   end

   // credits: results in flight plus results waiting in the queue
   logic [QCNT_W-1:0] used_ff, used_in;
   logic              rsp_pop;

   assign rsp_pop   = rsp_valid & rsp_ready;
   assign req_ready = (used_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   always_comb begin
      used_in = used_ff - QCNT_W'(rsp_pop);
      if (accept) begin
         used_in = used_in + QCNT_W'(n_results);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // row of column cells, each talking to its left and right neighbor
   lgs_col_type [MAX_WIDTH-1:0] cols;
   logic [ROW_W-1:0]            next_a_row;
   logic [ROW_W-1:0]            next_b_row;

   for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
      lgs_col_type left_col;
      lgs_col_type right_col;
      logic        col_enable;

      assign col_enable = (GRID_WIDTH_W'(i) < eff_width);

      if (i == 0) begin : g_left_edge
         assign left_col = '0;
      end else begin : g_left_inner
         assign left_col = cols[i-1];
      end

      if (i == MAX_WIDTH - 1) begin : g_right_edge
         assign right_col = '0;
      end else begin : g_right_inner
         assign right_col = cols[i+1];
      end

      lgs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (accept),
         .is_first   (is_first),
         .is_last    (is_last),
         .col_enable (col_enable),
         .row_bit    (req_row_bits[i]),
         .left_col   (left_col),
         .right_col  (right_col),
         .own_col    (cols[i]),
         .next_a     (next_a_row[i]),
         .next_b     (next_b_row[i])
      );
   end

   // columns beyond MAX_WIDTH stay dead
   if (MAX_WIDTH < ROW_W) begin : g_pad
      assign next_a_row[ROW_W-1:MAX_WIDTH] = '0;
      assign next_b_row[ROW_W-1:MAX_WIDTH] = '0;
   end

   // control travelling beside the data: stage 1 with the cells, then 2, 3
   lgs_ctrl_type s1_ctrl_ff, s1_ctrl_in;
   lgs_ctrl_type s2_ctrl_ff;
   lgs_ctrl_type s3_ctrl_ff;

   always_comb begin
      s1_ctrl_in = '0;
      if (accept) begin
         s1_ctrl_in.emit_a = !is_first;
         s1_ctrl_in.emit_b = is_last;
         s1_ctrl_in.idx_a  = IDX_W'(rows_seen_ff - CntW'(1));
         s1_ctrl_in.idx_b  = IDX_W'(rows_seen_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
         s3_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
         s2_ctrl_ff <= s1_ctrl_ff;
         s3_ctrl_ff <= s2_ctrl_ff;
      end
   end

   // row data delayed to line up with the population counts
   logic [ROW_W-1:0] row_a_s2_ff, row_a_s3_ff;
   logic [ROW_W-1:0] row_b_s2_ff, row_b_s3_ff;

   always_ff @(posedge clock) begin
      row_a_s2_ff <= next_a_row;
      row_a_s3_ff <= row_a_s2_ff;
      row_b_s2_ff <= next_b_row;
      row_b_s3_ff <= row_b_s2_ff;
   end

   logic [POP_W-1:0] pop_a;
   logic [POP_W-1:0] pop_b;

   lgs_popcount u_pop_a (
      .clock   (clock),
      .bits_in (next_a_row),
      .pop_out (pop_a)
   );

   lgs_popcount u_pop_b (
      .clock   (clock),
      .bits_in (next_b_row),
      .pop_out (pop_b)
   );

   // running population, saturating at the field's top value
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W:0]   sum_a;
   logic [TOTAL_W:0]   sum_b;
   logic [TOTAL_W-1:0] total_a;
   logic [TOTAL_W-1:0] base_b;
   logic [TOTAL_W-1:0] total_b;

   always_comb begin
      sum_a   = {1'b0, total_ff} + (TOTAL_W + 1)'(pop_a);
      total_a = sum_a[TOTAL_W] ? '1 : sum_a[TOTAL_W-1:0];
      base_b  = s3_ctrl_ff.emit_a ? total_a : total_ff;
      sum_b   = {1'b0, base_b} + (TOTAL_W + 1)'(pop_b);
      total_b = sum_b[TOTAL_W] ? '1 : sum_b[TOTAL_W-1:0];
      // frame end restarts the count
      if (s3_ctrl_ff.emit_b) begin
         total_in = '0;
      end else if (s3_ctrl_ff.emit_a) begin
         total_in = total_a;
      end else begin
         total_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // results into the queue, row r-1 ahead of the last row
   lgs_result_type res_a;
   lgs_result_type res_b;
   lgs_result_type res_out;

   always_comb begin
      res_a.next_row         = row_a_s3_ff;
      res_a.row_index        = s3_ctrl_ff.idx_a;
      res_a.row_population   = pop_a;
      res_a.total_population = total_a;
      res_a.frame_done       = 1'b0;
      res_b.next_row         = row_b_s3_ff;
      res_b.row_index        = s3_ctrl_ff.idx_b;
      res_b.row_population   = pop_b;
      res_b.total_population = total_b;
      res_b.frame_done       = 1'b1;
   end

   lgs_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (s3_ctrl_ff.emit_a),
      .data_a    (res_a),
      .push_b    (s3_ctrl_ff.emit_b),
      .data_b    (res_b),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (res_out)
   );

   assign rsp_next_row         = res_out.next_row;
   assign rsp_row_index        = res_out.row_index;
   assign rsp_row_population   = res_out.row_population;
   assign rsp_total_population = res_out.total_population;
   assign rsp_frame_done       = res_out.frame_done;

endmodule

### sv/lgs_checker.sv
// port-level checks of the life generation step block, bound to the top level
module lgs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [lgs_pkg::ROW_W-1:0]         req_row_bits,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [lgs_pkg::ROW_W-1:0]         rsp_next_row,
   input logic [lgs_pkg::IDX_W-1:0]         rsp_row_index,
   input logic [lgs_pkg::POP_W-1:0]         rsp_row_population,
   input logic [lgs_pkg::TOTAL_W-1:0]       rsp_total_population,
   input logic                              rsp_frame_done
);
   import lgs_pkg::*;

   // stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_row_bits))
      else $error("request changed while stalled");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_row)
         && $stable(rsp_row_index) && $stable(rsp_total_population)
         && $stable(rsp_frame_done))
      else $error("response changed while stalled");

   // row count fits a row, running count includes it
   a_pop_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_population <= POP_W'(ROW_W))
         && (rsp_total_population >= TOTAL_W'(rsp_row_population)))
      else $error("population fields inconsistent");

   // population of a row matches its bits
   a_pop_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (POP_W'($countones(rsp_next_row)) == rsp_row_population))
      else $error("row population does not match row");

   // reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

endmodule

bind life_generation_step lgs_checker u_lgs_checker (.*);
